@@ rtl/cdvs_pkg.sv @@
// ----------------------------------------------------------------------------
// cdvs_pkg: shared types and constants of the value smoother
// Field widths, fixed-point constants, sequencer states, the request structs
// of the bit-serial multiply and divide units, and saturating add/subtract.
// ----------------------------------------------------------------------------
package cdvs_pkg;

	// Field and state widths.
	localparam int VALUE_W   = 32;
	localparam int TDELTA_W  = 16;
	localparam int ELAPSED_W = 24;
	localparam int RATE_W    = 24;
	localparam int FS_W      = 31;
	localparam int FILL_W    = 17;

	// Bit-serial multiplier: A is parallel, B is consumed one bit per cycle.
	localparam int MUL_A_W = 41;
	localparam int MUL_B_W = 25;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;
	localparam int MUL_R_W = MUL_P_W - 16;
	localparam int MUL_CNT_W = $clog2(MUL_B_W);

	// Restoring divider: one quotient bit per cycle.
	localparam int DIV_N_W = 48;
	localparam int DIV_D_W = 39;
	localparam int DIV_Q_W = 17;
	localparam int DIV_CNT_W = $clog2(DIV_N_W);

	// Polynomial and timing constants.
	localparam int X_W   = 25;
	localparam int X2_W  = 33;
	localparam int X3_W  = 41;
	localparam logic [MUL_B_W-1:0] K_048  = MUL_B_W'(31457);
	localparam logic [MUL_B_W-1:0] K_0235 = MUL_B_W'(15401);
	localparam logic [X_W-1:0] X_MAX = X_W'(1 << 24);
	localparam logic [FILL_W-1:0] ONE_Q16 = FILL_W'(65536);
	localparam logic [ELAPSED_W-1:0] MIN_PERIOD = ELAPSED_W'(1049);
	localparam logic signed [VALUE_W-1:0] VMAX = {1'b0, {(VALUE_W-1){1'b1}}};
	localparam logic signed [VALUE_W-1:0] VMIN = {1'b1, {(VALUE_W-1){1'b0}}};

	// Input kinds and register indexes.
	localparam logic KIND_TICK = 1'b0;
	localparam logic KIND_GOAL = 1'b1;
	localparam logic CFG_DAMPING_RATE = 1'b0;
	localparam logic CFG_FULL_SCALE   = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL_X,
		ST_MUL_X2,
		ST_MUL_X3,
		ST_MUL_K1,
		ST_MUL_K2,
		ST_DIV_E,
		ST_MUL_A,
		ST_MUL_T,
		ST_MUL_V,
		ST_MUL_V2,
		ST_MUL_O,
		ST_SETTLE,
		ST_FILL,
		ST_FILL_DIV,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic               start;
		logic [MUL_A_W-1:0] a;
		logic [MUL_B_W-1:0] b;
	} mul_req_t;

	typedef struct packed {
		logic               start;
		logic [DIV_N_W-1:0] n;
		logic [DIV_D_W-1:0] d;
	} div_req_t;

	// Saturating signed add and subtract.
	function automatic logic signed [VALUE_W-1:0] sat_add(
		input logic signed [VALUE_W-1:0] a,
		input logic signed [VALUE_W-1:0] b
	);
		logic signed [VALUE_W:0] s;
		s = {a[VALUE_W-1], a} + {b[VALUE_W-1], b};
		if (s[VALUE_W] != s[VALUE_W-1]) begin
			return s[VALUE_W] ? VMIN : VMAX;
		end
		return s[VALUE_W-1:0];
	endfunction

	function automatic logic signed [VALUE_W-1:0] sat_sub(
		input logic signed [VALUE_W-1:0] a,
		input logic signed [VALUE_W-1:0] b
	);
		logic signed [VALUE_W:0] s;
		s = {a[VALUE_W-1], a} - {b[VALUE_W-1], b};
		if (s[VALUE_W] != s[VALUE_W-1]) begin
			return s[VALUE_W] ? VMIN : VMAX;
		end
		return s[VALUE_W-1:0];
	endfunction

endpackage

@@ rtl/cdvs_mul.sv @@
// ----------------------------------------------------------------------------
// cdvs_mul: bit-serial shift-add multiplier with rounding
// Takes one bit of B per cycle and returns round(A*B / 2^16), ties up.
// ----------------------------------------------------------------------------
module cdvs_mul (
	input  logic                           clk,
	input  logic                           arst_n,
	input  cdvs_pkg::mul_req_t             req,
	output logic                           done,
	output logic [cdvs_pkg::MUL_R_W-1:0]   res
);

	logic                            run_q;
	logic                            done_q;
	logic [cdvs_pkg::MUL_CNT_W-1:0]  cnt_q;
	logic [cdvs_pkg::MUL_A_W-1:0]    a_q;
	logic [cdvs_pkg::MUL_B_W-1:0]    b_q;
	logic [cdvs_pkg::MUL_P_W-1:0]    acc_q;
	logic [cdvs_pkg::MUL_A_W:0]      hi;

	// Add the partial product into the upper half, then shift right.
	assign hi = {1'b0, acc_q[cdvs_pkg::MUL_P_W-1:cdvs_pkg::MUL_B_W]}
		+ (b_q[0] ? {1'b0, a_q} : '0);

	// Control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == cdvs_pkg::MUL_CNT_W'(cdvs_pkg::MUL_B_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Operand and accumulator shift registers.
	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q   <= req.a;
			b_q   <= req.b;
			acc_q <= '0;
		end else if (run_q) begin
			b_q   <= b_q >> 1;
			acc_q <= {hi, acc_q[cdvs_pkg::MUL_B_W-1:1]};
		end
	end

	assign done = done_q;
	assign res  = acc_q[cdvs_pkg::MUL_P_W-1:16] + cdvs_pkg::MUL_R_W'(acc_q[15]);

endmodule

@@ rtl/cdvs_div.sv @@
// ----------------------------------------------------------------------------
// cdvs_div: restoring divider, one quotient bit per cycle
// Returns the low quotient bits of floor(N / D).
// ----------------------------------------------------------------------------
module cdvs_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  cdvs_pkg::div_req_t            req,
	output logic                          done,
	output logic [cdvs_pkg::DIV_Q_W-1:0]  quo
);

	logic                            run_q;
	logic                            done_q;
	logic [cdvs_pkg::DIV_CNT_W-1:0]  cnt_q;
	logic [cdvs_pkg::DIV_N_W-1:0]    num_q;
	logic [cdvs_pkg::DIV_D_W-1:0]    den_q;
	logic [cdvs_pkg::DIV_D_W-1:0]    rem_q;
	logic [cdvs_pkg::DIV_Q_W-1:0]    quo_q;
	logic [cdvs_pkg::DIV_D_W:0]      trial;
	logic [cdvs_pkg::DIV_D_W:0]      diff;
	logic                            fits;

	// Trial subtraction of the divisor from the shifted remainder.
	assign trial = {rem_q, num_q[cdvs_pkg::DIV_N_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign fits  = trial >= {1'b0, den_q};

	// Control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == cdvs_pkg::DIV_CNT_W'(cdvs_pkg::DIV_N_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Dividend, remainder and quotient shift registers.
	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.n;
			den_q <= req.d;
			rem_q <= '0;
			quo_q <= '0;
		end else if (run_q) begin
			num_q <= num_q << 1;
			rem_q <= fits ? diff[cdvs_pkg::DIV_D_W-1:0] : trial[cdvs_pkg::DIV_D_W-1:0];
			quo_q <= {quo_q[cdvs_pkg::DIV_Q_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

@@ rtl/critically_damped_value_smoother.sv @@
// ----------------------------------------------------------------------------
// critically_damped_value_smoother: spring smoothing of a displayed level
// A tick that does not move goes straight to its result beat; a set-goal item
// or a snap runs the fill step; a full spring step runs ten passes of the
// bit-serial multiplier and one or two divisions.
// One item is worked at a time; the next is taken once the result is queued.
// Reset clears level, goal, velocity, elapsed time and fill; damping rate is
// zero and full scale is 1.0.
// ----------------------------------------------------------------------------
module critically_damped_value_smoother (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic                                  kind,
	input  logic [cdvs_pkg::TDELTA_W-1:0]         time_delta,
	input  logic signed [cdvs_pkg::VALUE_W-1:0]   goal_value,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic signed [cdvs_pkg::VALUE_W-1:0]   level,
	output logic [cdvs_pkg::FILL_W-1:0]           fill_fraction,
	output logic                                  moved,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic                                  cfg_index,
	input  logic [cdvs_pkg::FS_W-1:0]             cfg_data
);

	cdvs_pkg::state_t state_q, state_d;

	// Architectural state.
	logic signed [cdvs_pkg::VALUE_W-1:0] cur_q, goal_q, vel_q;
	logic [cdvs_pkg::ELAPSED_W-1:0]      el_q;
	logic [cdvs_pkg::RATE_W-1:0]         w_q;
	logic [cdvs_pkg::FS_W-1:0]           fs_q;
	logic [cdvs_pkg::FILL_W-1:0]         fill_held_q;

	// Step working registers.
	logic [cdvs_pkg::X_W-1:0]            x_q;
	logic [cdvs_pkg::X2_W-1:0]           x2_q;
	logic [cdvs_pkg::X3_W-1:0]           x3_q;
	logic [cdvs_pkg::DIV_D_W-1:0]        den_q;
	logic [cdvs_pkg::DIV_Q_W-1:0]        e_q;
	logic signed [cdvs_pkg::VALUE_W-1:0] chg_q, a_q, temp_q, v1_q, vnew_q, out_q;
	logic signed [cdvs_pkg::VALUE_W-1:0] fill_src_q;
	logic                                moved_q, cfg_fill_q, op_busy_q;

	// Result register.
	logic                                out_valid_q;
	logic signed [cdvs_pkg::VALUE_W-1:0] level_q;
	logic [cdvs_pkg::FILL_W-1:0]         fill_q;
	logic                                moved_out_q;

	cdvs_pkg::mul_req_t                  mul_req;
	cdvs_pkg::div_req_t                  div_req;
	logic                                mul_done, div_done;
	logic [cdvs_pkg::MUL_R_W-1:0]        mul_res;
	logic [cdvs_pkg::DIV_Q_W-1:0]        div_quo;

	logic                                in_acc, cfg_we, emit;
	logic [cdvs_pkg::ELAPSED_W:0]        el_sum;
	logic [cdvs_pkg::ELAPSED_W-1:0]      el_new;
	logic                                step_due;
	logic [cdvs_pkg::FS_W-1:0]           fs_eff;
	logic                                src_low, src_high;
	logic signed [cdvs_pkg::VALUE_W-1:0] op_sel;
	logic                                op_neg;
	logic [cdvs_pkg::VALUE_W-1:0]        op_mag;
	logic [cdvs_pkg::MUL_R_W-1:0]        lim, q_mag;
	logic signed [cdvs_pkg::VALUE_W-1:0] mulq;
	logic [cdvs_pkg::X_W-1:0]            x_clamped;
	logic                                overshoot;
	logic signed [cdvs_pkg::VALUE_W-1:0] settle_lvl;

	// Handshakes.
	assign cfg_ready = (state_q == cdvs_pkg::ST_IDLE);
	assign in_stall  = (state_q != cdvs_pkg::ST_IDLE) || cfg_valid;
	assign in_acc    = in_valid && !in_stall;
	assign cfg_we    = cfg_valid && cfg_ready;
	assign emit      = (state_q == cdvs_pkg::ST_EMIT) && (!out_valid_q || !out_stall);

	// Elapsed time accumulates with saturation.
	assign el_sum   = {1'b0, el_q} + (cdvs_pkg::ELAPSED_W + 1)'(time_delta);
	assign el_new   = el_sum[cdvs_pkg::ELAPSED_W] ? '1 : el_sum[cdvs_pkg::ELAPSED_W-1:0];
	assign step_due = (cur_q != goal_q) && (el_new >= cdvs_pkg::MIN_PERIOD);

	// Fill bounds; a zero full scale acts as one.
	assign fs_eff   = (fs_q == '0) ? cdvs_pkg::FS_W'(1) : fs_q;
	assign src_low  = (fill_src_q <= 0);
	assign src_high = fill_src_q[cdvs_pkg::VALUE_W-2:0] >= fs_eff;

	// Signed operand of the current rounded multiply.
	always_comb begin
		unique case (state_q)
			cdvs_pkg::ST_MUL_A:  op_sel = chg_q;
			cdvs_pkg::ST_MUL_T:  op_sel = a_q;
			cdvs_pkg::ST_MUL_V:  op_sel = temp_q;
			cdvs_pkg::ST_MUL_V2: op_sel = v1_q;
			cdvs_pkg::ST_MUL_O:  op_sel = cdvs_pkg::sat_add(chg_q, temp_q);
			default:             op_sel = '0;
		endcase
	end

	// Sign-magnitude around the unsigned multiplier, saturating the result.
	assign op_neg = op_sel[cdvs_pkg::VALUE_W-1];
	assign op_mag = op_neg ? -op_sel : op_sel;
	assign lim    = op_neg ? cdvs_pkg::MUL_R_W'(64'h8000_0000)
		: cdvs_pkg::MUL_R_W'(64'h7FFF_FFFF);
	assign q_mag  = (mul_res > lim) ? lim : mul_res;
	assign mulq   = op_neg ? -q_mag[cdvs_pkg::VALUE_W-1:0] : q_mag[cdvs_pkg::VALUE_W-1:0];

	assign x_clamped = (mul_res > cdvs_pkg::MUL_R_W'(cdvs_pkg::X_MAX))
		? cdvs_pkg::X_MAX : mul_res[cdvs_pkg::X_W-1:0];

	// Overshoot pins the level to the goal.
	assign overshoot  = (goal_q > cur_q) == (out_q > goal_q);
	assign settle_lvl = overshoot ? goal_q : out_q;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cdvs_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Sequencer: next state and unit requests.
	always_comb begin
		state_d = state_q;
		mul_req = '0;
		div_req = '0;
		unique case (state_q)
			cdvs_pkg::ST_IDLE: begin
				if (cfg_we && cfg_index == cdvs_pkg::CFG_FULL_SCALE) begin
					state_d = cdvs_pkg::ST_FILL;
				end else if (in_acc) begin
					if (kind == cdvs_pkg::KIND_GOAL) begin
						state_d = cdvs_pkg::ST_FILL;
					end else if (step_due) begin
						state_d = (w_q == '0) ? cdvs_pkg::ST_FILL : cdvs_pkg::ST_MUL_X;
					end else begin
						state_d = cdvs_pkg::ST_EMIT;
					end
				end
			end
			cdvs_pkg::ST_MUL_X: begin
				mul_req.a = cdvs_pkg::MUL_A_W'(w_q);
				mul_req.b = cdvs_pkg::MUL_B_W'(el_q);
				if (mul_done) state_d = cdvs_pkg::ST_MUL_X2;
			end
			cdvs_pkg::ST_MUL_X2: begin
				mul_req.a = cdvs_pkg::MUL_A_W'(x_q);
				mul_req.b = x_q;
				if (mul_done) state_d = cdvs_pkg::ST_MUL_X3;
			end
			cdvs_pkg::ST_MUL_X3: begin
				mul_req.a = cdvs_pkg::MUL_A_W'(x2_q);
				mul_req.b = x_q;
				if (mul_done) state_d = cdvs_pkg::ST_MUL_K1;
			end
			cdvs_pkg::ST_MUL_K1: begin
				mul_req.a = cdvs_pkg::MUL_A_W'(x2_q);
				mul_req.b = cdvs_pkg::K_048;
				if (mul_done) state_d = cdvs_pkg::ST_MUL_K2;
			end
			cdvs_pkg::ST_MUL_K2: begin
				mul_req.a = x3_q;
				mul_req.b = cdvs_pkg::K_0235;
				if (mul_done) state_d = cdvs_pkg::ST_DIV_E;
			end
			cdvs_pkg::ST_DIV_E: begin
				div_req.n = cdvs_pkg::DIV_N_W'(64'h1_0000_0000)
					+ cdvs_pkg::DIV_N_W'(den_q >> 1);
				div_req.d = den_q;
				if (div_done) state_d = cdvs_pkg::ST_MUL_A;
			end
			cdvs_pkg::ST_MUL_A: begin
				mul_req.a = cdvs_pkg::MUL_A_W'(op_mag);
				mul_req.b = cdvs_pkg::MUL_B_W'(w_q);
				if (mul_done) state_d = cdvs_pkg::ST_MUL_T;
			end
			cdvs_pkg::ST_MUL_T: begin
				mul_req.a = cdvs_pkg::MUL_A_W'(op_mag);
				mul_req.b = cdvs_pkg::MUL_B_W'(el_q);
				if (mul_done) state_d = cdvs_pkg::ST_MUL_V;
			end
			cdvs_pkg::ST_MUL_V: begin
				mul_req.a = cdvs_pkg::MUL_A_W'(op_mag);
				mul_req.b = cdvs_pkg::MUL_B_W'(w_q);
				if (mul_done) state_d = cdvs_pkg::ST_MUL_V2;
			end
			cdvs_pkg::ST_MUL_V2: begin
				mul_req.a = cdvs_pkg::MUL_A_W'(op_mag);
				mul_req.b = cdvs_pkg::MUL_B_W'(e_q);
				if (mul_done) state_d = cdvs_pkg::ST_MUL_O;
			end
			cdvs_pkg::ST_MUL_O: begin
				mul_req.a = cdvs_pkg::MUL_A_W'(op_mag);
				mul_req.b = cdvs_pkg::MUL_B_W'(e_q);
				if (mul_done) state_d = cdvs_pkg::ST_SETTLE;
			end
			cdvs_pkg::ST_SETTLE: begin
				state_d = cdvs_pkg::ST_FILL;
			end
			cdvs_pkg::ST_FILL: begin
				if (src_low || src_high) begin
					state_d = cfg_fill_q ? cdvs_pkg::ST_IDLE : cdvs_pkg::ST_EMIT;
				end else begin
					state_d = cdvs_pkg::ST_FILL_DIV;
				end
			end
			cdvs_pkg::ST_FILL_DIV: begin
				div_req.n = cdvs_pkg::DIV_N_W'(fill_src_q[cdvs_pkg::VALUE_W-2:0]) << 16;
				div_req.d = cdvs_pkg::DIV_D_W'(fs_eff);
				if (div_done) begin
					state_d = cfg_fill_q ? cdvs_pkg::ST_IDLE : cdvs_pkg::ST_EMIT;
				end
			end
			cdvs_pkg::ST_EMIT: begin
				if (emit) state_d = cdvs_pkg::ST_IDLE;
			end
			default: state_d = cdvs_pkg::ST_IDLE;
		endcase

		// Launch the unit once on entry to a unit state.
		unique case (state_q)
			cdvs_pkg::ST_MUL_X, cdvs_pkg::ST_MUL_X2, cdvs_pkg::ST_MUL_X3,
			cdvs_pkg::ST_MUL_K1, cdvs_pkg::ST_MUL_K2, cdvs_pkg::ST_MUL_A,
			cdvs_pkg::ST_MUL_T, cdvs_pkg::ST_MUL_V, cdvs_pkg::ST_MUL_V2,
			cdvs_pkg::ST_MUL_O: mul_req.start = !op_busy_q;
			cdvs_pkg::ST_DIV_E, cdvs_pkg::ST_FILL_DIV: div_req.start = !op_busy_q;
			default: begin
				mul_req.start = 1'b0;
				div_req.start = 1'b0;
			end
		endcase
	end

	cdvs_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.done   (mul_done),
		.res    (mul_res)
	);

	cdvs_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.done   (div_done),
		.quo    (div_quo)
	);

	// Architectural state and control flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q       <= '0;
			goal_q      <= '0;
			vel_q       <= '0;
			el_q        <= '0;
			w_q         <= '0;
			fs_q        <= cdvs_pkg::FS_W'(65536);
			fill_held_q <= '0;
			moved_q     <= 1'b0;
			cfg_fill_q  <= 1'b0;
			op_busy_q   <= 1'b0;
		end else begin
			if (mul_req.start || div_req.start) begin
				op_busy_q <= 1'b1;
			end else if (mul_done || div_done) begin
				op_busy_q <= 1'b0;
			end

			if (cfg_we) begin
				unique case (cfg_index)
					cdvs_pkg::CFG_DAMPING_RATE: w_q <= cfg_data[cdvs_pkg::RATE_W-1:0];
					cdvs_pkg::CFG_FULL_SCALE: begin
						fs_q       <= cfg_data;
						cfg_fill_q <= 1'b1;
					end
				endcase
			end else if (in_acc) begin
				cfg_fill_q <= 1'b0;
				if (kind == cdvs_pkg::KIND_GOAL) begin
					goal_q  <= goal_value;
					moved_q <= 1'b0;
				end else if (step_due) begin
					moved_q <= 1'b1;
					if (w_q == '0) begin
						cur_q <= goal_q;
						el_q  <= '0;
					end else begin
						el_q <= el_new;
					end
				end else begin
					el_q    <= el_new;
					moved_q <= 1'b0;
				end
			end

			// Close a spring step.
			if (state_q == cdvs_pkg::ST_SETTLE) begin
				cur_q <= settle_lvl;
				vel_q <= overshoot ? '0 : vnew_q;
				el_q  <= '0;
			end

			// Fill fraction from the chosen source.
			if (state_q == cdvs_pkg::ST_FILL) begin
				if (src_low) begin
					fill_held_q <= '0;
				end else if (src_high) begin
					fill_held_q <= cdvs_pkg::ONE_Q16;
				end
			end
			if (state_q == cdvs_pkg::ST_FILL_DIV && div_done) begin
				fill_held_q <= div_quo;
			end
		end
	end

	// Step working registers.
	always_ff @(posedge clk) begin
		if (cfg_we) begin
			fill_src_q <= goal_q;
		end else if (in_acc) begin
			chg_q      <= cdvs_pkg::sat_sub(cur_q, goal_q);
			fill_src_q <= (kind == cdvs_pkg::KIND_GOAL) ? goal_value : goal_q;
		end
		if (state_q == cdvs_pkg::ST_SETTLE) begin
			fill_src_q <= settle_lvl;
		end
		if (mul_done) begin
			unique case (state_q)
				cdvs_pkg::ST_MUL_X:  x_q  <= x_clamped;
				cdvs_pkg::ST_MUL_X2: x2_q <= mul_res[cdvs_pkg::X2_W-1:0];
				cdvs_pkg::ST_MUL_X3: x3_q <= mul_res[cdvs_pkg::X3_W-1:0];
				cdvs_pkg::ST_MUL_K1: den_q <= cdvs_pkg::DIV_D_W'(65536)
					+ cdvs_pkg::DIV_D_W'(x_q) + cdvs_pkg::DIV_D_W'(mul_res);
				cdvs_pkg::ST_MUL_K2: den_q <= den_q + cdvs_pkg::DIV_D_W'(mul_res);
				cdvs_pkg::ST_MUL_A:  a_q    <= cdvs_pkg::sat_add(vel_q, mulq);
				cdvs_pkg::ST_MUL_T:  temp_q <= mulq;
				cdvs_pkg::ST_MUL_V:  v1_q   <= cdvs_pkg::sat_sub(vel_q, mulq);
				cdvs_pkg::ST_MUL_V2: vnew_q <= mulq;
				cdvs_pkg::ST_MUL_O:  out_q  <= cdvs_pkg::sat_add(goal_q, mulq);
				default: ;
			endcase
		end
		if (state_q == cdvs_pkg::ST_DIV_E && div_done) begin
			e_q <= div_quo;
		end
	end

	// Output register: a result beat waits here while the next item runs.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			level_q     <= cur_q;
			fill_q      <= fill_held_q;
			moved_out_q <= moved_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign level         = level_q;
	assign fill_fraction = fill_q;
	assign moved         = moved_out_q;

`ifndef NO_ASSERTIONS
	// A unit only finishes work that the sequencer launched.
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(mul_done || div_done) |-> op_busy_q)
		else $error("unit done without a pending request");

	// The held fill never exceeds one.
	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_held_q <= cdvs_pkg::ONE_Q16)
		else $error("fill fraction above one");

	// A queued result beat is presented on the next cycle.
	a_emit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> out_valid)
		else $error("result beat lost after emit");

	// Only one unit runs at a time.
	a_one_unit: assert property (@(posedge clk) disable iff (!arst_n)
		!(mul_req.start && div_req.start))
		else $error("multiplier and divider launched together");
`endif

endmodule
